// ===== hw/rtl/crtd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crtd_pkg: shared types and constants of the motor run timer
// Event codes, status codes, register indexes, lamp patterns and reset values.
// ----------------------------------------------------------------------------
package crtd_pkg;

    // ADC sample width default
    localparam int SAMPLE_BITS_DEF = 12;

    // Widths of the fixed fields
    localparam int SEC_W   = 7;
    localparam int HOLD_W  = 4;
    localparam int LEVEL_W = 7;
    localparam int PWM_W   = 16;
    localparam int LAMP_W  = 3;

    // Configuration reset values
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = 4'd5;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST  = 7'd2;
    localparam logic [PWM_W-1:0]   PWM_TOP_RST    = 16'd4999;
    localparam logic [PWM_W-1:0]   DUTY_RST       = 16'd4999;

    // Seconds accepted by set must stay below this
    localparam int SET_LIMIT   = 99;
    // Top of the mapped ADC level
    localparam int LEVEL_SCALE = 99;

    // Lamp patterns: bit0 red, bit1 blue, bit2 green
    localparam logic [LAMP_W-1:0] LAMP_OFF   = 3'b000;
    localparam logic [LAMP_W-1:0] LAMP_RED   = 3'b001;
    localparam logic [LAMP_W-1:0] LAMP_BLUE  = 3'b010;
    localparam logic [LAMP_W-1:0] LAMP_GREEN = 3'b100;

    // Event codes carried by one input word
    typedef enum logic [3:0] {
        MODE_TICK    = 4'd0,
        MODE_BUTTON1 = 4'd1,
        MODE_BUTTON2 = 4'd2,
        MODE_SET     = 4'd3,
        MODE_START   = 4'd4,
        MODE_STOP    = 4'd5,
        MODE_PAUSE   = 4'd6,
        MODE_RESUME  = 4'd7,
        MODE_SAMPLE  = 4'd8
    } t_mode;

    // Status codes returned with each result word
    typedef enum logic [3:0] {
        ST_NONE        = 4'd0,
        ST_OK          = 4'd1,
        ST_RANGE       = 4'd2,
        ST_NOT_SET     = 4'd3,
        ST_RUNNING     = 4'd4,
        ST_STOPPED     = 4'd5,
        ST_PAUSED      = 4'd6,
        ST_RESUMED     = 4'd7,
        ST_NOT_RUNNING = 4'd8,
        ST_TIMEOUT     = 4'd9
    } t_status;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_HOLD_TICKS = 2'd0,
        REG_THRESHOLD  = 2'd1,
        REG_PWM_TOP    = 2'd2
    } t_reg;

endpackage

// ===== hw/rtl/crtd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crtd_div: divide by ADC full scale
// Exact floor of a product over (2^SAMPLE_BITS - 1) using folded adds:
// with p = a*2^n + b, p = a*(2^n - 1) + (a + b), so each fold moves the
// high part into the quotient and leaves a smaller remainder.
// ----------------------------------------------------------------------------
module crtd_div #(
    parameter int SAMPLE_BITS = crtd_pkg::SAMPLE_BITS_DEF
) (
    input  logic [crtd_pkg::PWM_W+SAMPLE_BITS-1:0] i_prod,
    output logic [crtd_pkg::PWM_W-1:0]             o_quot
);

    localparam int PW    = crtd_pkg::PWM_W + SAMPLE_BITS;
    localparam int FOLDS = 4;
    localparam logic [PW-1:0] FULL = PW'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [PW-1:0] t;
    logic [PW-1:0] a;
    logic [PW-1:0] q;

    // Fold the remainder until it lies below twice the full scale
    always_comb begin
        t = i_prod;
        q = '0;
        a = '0;
        for (int k = 0; k < FOLDS; k++) begin
            a = t >> SAMPLE_BITS;
            q = q + a;
            t = a + (t & FULL);
        end
        if (t >= FULL) begin
            q = q + PW'(1);
        end
    end

    assign o_quot = q[crtd_pkg::PWM_W-1:0];

endmodule

// ===== hw/rtl/countdown_run_timer_with_adc_display.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_run_timer_with_adc_display: motor run timer with ADC display
// Event-driven countdown, lamp and motor control, ADC to PWM compare map.
// ----------------------------------------------------------------------------
// One input word carries one event (tick, button, command or ADC sample) and
// gives one result word. A word can be accepted every cycle while the result
// side keeps up; its result moves from the stage register into the output
// register once that register is free or being read: the timer state, the
// ADC level and the sample times pwm_top product are settled at the
// accepting edge, then the product is divided by the ADC full scale in the
// second stage in front of the output register. With the result side
// stalled, the stage register and the output register hold two words and
// o_ready drops until one leaves. Configuration goes through the APB port
// at byte addresses 0 (hold_ticks), 4 (change_threshold) and 8 (pwm_top);
// the user must write it only while no word is in flight (not enforced).
module countdown_run_timer_with_adc_display #(
    parameter int SAMPLE_BITS = crtd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input words
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [3:0]             i_mode,
    input  logic [SAMPLE_BITS-1:0] i_value,
    // result words
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_motor_drive,
    output logic [2:0]             o_led_colour,
    output logic [6:0]             o_remaining_seconds,
    output logic [6:0]             o_display_level,
    output logic [15:0]            o_pwm_compare,
    output logic [3:0]             o_status,
    output logic                   o_running,
    output logic                   o_playing,
    output logic                   o_timed_out,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = crtd_pkg::PWM_W + SB;
    localparam int VW = SB + crtd_pkg::LEVEL_W;
    localparam logic [SB:0] FULL_EXT = (SB+1)'((64'd1 << SB) - 64'd1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]  r_hold_ticks;
    logic [6:0]  r_change_threshold;
    logic [15:0] r_pwm_top;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks       <= crtd_pkg::HOLD_TICKS_RST;
            r_change_threshold <= crtd_pkg::THRESHOLD_RST;
            r_pwm_top          <= crtd_pkg::PWM_TOP_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                crtd_pkg::REG_HOLD_TICKS: r_hold_ticks       <= pwdata[3:0];
                crtd_pkg::REG_THRESHOLD:  r_change_threshold <= pwdata[6:0];
                crtd_pkg::REG_PWM_TOP:    r_pwm_top          <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (paddr[3:2])
            crtd_pkg::REG_HOLD_TICKS: prdata = {28'd0, r_hold_ticks};
            crtd_pkg::REG_THRESHOLD:  prdata = {25'd0, r_change_threshold};
            crtd_pkg::REG_PWM_TOP:    prdata = {16'd0, r_pwm_top};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: stage one holds a settled word, stage two is the output
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic in_accept;
    logic out_load;

    assign out_load  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || out_load;
    assign in_accept = i_valid && o_ready;
    assign o_valid   = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Timer state
    // ------------------------------------------------------------------
    logic [6:0] r_seconds_left, n_seconds_left;
    logic       r_session_on,   n_session_on;
    logic       r_counting,     n_counting;
    logic       r_expired,      n_expired;
    logic       r_blink_phase,  n_blink_phase;
    logic [2:0] r_lamp_bits,    n_lamp_bits;
    logic       r_drive_pin,    n_drive_pin;
    logic       r_hold_active,  n_hold_active;
    logic [3:0] r_hold_count,   n_hold_count;
    logic [6:0] r_last_level,   n_last_level;
    logic [6:0] r_shown_level,  n_shown_level;
    crtd_pkg::t_status n_status;

    // Map the sample onto 0..99: floor(x*99 / full scale)
    logic [VW-1:0] lvl_prod;
    logic [6:0]    lvl_hi;
    logic [SB:0]   lvl_fold;
    logic [6:0]    level;
    logic [6:0]    level_diff;

    assign lvl_prod   = VW'(i_value) * VW'(crtd_pkg::LEVEL_SCALE);
    assign lvl_hi     = lvl_prod[VW-1:SB];
    assign lvl_fold   = {1'b0, lvl_prod[SB-1:0]} + (SB+1)'(lvl_hi);
    assign level      = lvl_hi + 7'(lvl_fold >= FULL_EXT);
    assign level_diff = (level > r_last_level) ? (level - r_last_level)
                                               : (r_last_level - level);

    // Next state for the accepted event
    always_comb begin
        n_seconds_left = r_seconds_left;
        n_session_on   = r_session_on;
        n_counting     = r_counting;
        n_expired      = r_expired;
        n_blink_phase  = r_blink_phase;
        n_lamp_bits    = r_lamp_bits;
        n_drive_pin    = r_drive_pin;
        n_hold_active  = r_hold_active;
        n_hold_count   = r_hold_count;
        n_last_level   = r_last_level;
        n_shown_level  = r_shown_level;
        n_status       = crtd_pkg::ST_NONE;
        unique case (i_mode)
            crtd_pkg::MODE_TICK: begin
                // age the display hold first
                if (r_hold_active && (r_hold_count != 4'd0)) begin
                    n_hold_count = r_hold_count - 4'd1;
                    if (r_hold_count == 4'd1) begin
                        n_hold_active = 1'b0;
                    end
                end
                if (r_counting) begin
                    if (r_seconds_left != 7'd0) begin
                        n_drive_pin    = 1'b1;
                        n_seconds_left = r_seconds_left - 7'd1;
                        n_blink_phase  = !r_blink_phase;
                        n_lamp_bits    = r_blink_phase ? crtd_pkg::LAMP_OFF
                                                       : crtd_pkg::LAMP_GREEN;
                    end else begin
                        n_counting   = 1'b0;
                        n_session_on = 1'b0;
                        n_expired    = 1'b1;
                        n_drive_pin  = 1'b0;
                        n_lamp_bits  = crtd_pkg::LAMP_RED;
                        n_status     = crtd_pkg::ST_TIMEOUT;
                    end
                end
                if (!n_counting && n_session_on) begin
                    n_lamp_bits = crtd_pkg::LAMP_BLUE;
                end
            end
            crtd_pkg::MODE_BUTTON1: begin
                if (!r_session_on) begin
                    if (!r_expired) begin
                        n_session_on = 1'b1;
                        n_counting   = 1'b1;
                    end
                end else begin
                    n_session_on   = 1'b0;
                    n_counting     = 1'b0;
                    n_seconds_left = 7'd0;
                end
            end
            crtd_pkg::MODE_BUTTON2: begin
                if (r_session_on) begin
                    n_counting = !r_counting;
                end
            end
            crtd_pkg::MODE_SET: begin
                if (i_value < SB'(crtd_pkg::SET_LIMIT)) begin
                    n_seconds_left = i_value[6:0];
                    n_expired      = 1'b0;
                    n_lamp_bits    = crtd_pkg::LAMP_GREEN;
                    n_blink_phase  = 1'b1;
                    n_status       = crtd_pkg::ST_OK;
                end else begin
                    n_status = crtd_pkg::ST_RANGE;
                end
            end
            crtd_pkg::MODE_START: begin
                if (r_session_on) begin
                    n_status = crtd_pkg::ST_RUNNING;
                end else if (r_seconds_left == 7'd0) begin
                    n_status = crtd_pkg::ST_NOT_SET;
                end else begin
                    n_session_on = 1'b1;
                    n_counting   = 1'b1;
                    n_status     = crtd_pkg::ST_OK;
                end
            end
            crtd_pkg::MODE_STOP: begin
                if (r_session_on) begin
                    n_session_on   = 1'b0;
                    n_counting     = 1'b0;
                    n_seconds_left = 7'd0;
                    n_status       = crtd_pkg::ST_OK;
                end else begin
                    n_status = crtd_pkg::ST_STOPPED;
                end
            end
            crtd_pkg::MODE_PAUSE: begin
                if (!r_session_on) begin
                    n_status = crtd_pkg::ST_NOT_RUNNING;
                end else if (r_counting) begin
                    n_counting = 1'b0;
                    n_status   = crtd_pkg::ST_OK;
                end else begin
                    n_status = crtd_pkg::ST_PAUSED;
                end
            end
            crtd_pkg::MODE_RESUME: begin
                if (!r_session_on) begin
                    n_status = crtd_pkg::ST_NOT_RUNNING;
                end else if (!r_counting) begin
                    n_counting = 1'b1;
                    n_status   = crtd_pkg::ST_OK;
                end else begin
                    n_status = crtd_pkg::ST_RESUMED;
                end
            end
            crtd_pkg::MODE_SAMPLE: begin
                // refresh the shown level on a large move
                if (level_diff > r_change_threshold) begin
                    n_last_level  = level;
                    n_shown_level = level;
                    n_hold_count  = r_hold_ticks;
                    n_hold_active = (r_hold_ticks != 4'd0);
                end
            end
            default: ;
        endcase
    end

    // Update the timer state at acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seconds_left <= '0;
            r_session_on   <= 1'b0;
            r_counting     <= 1'b0;
            r_expired      <= 1'b0;
            r_blink_phase  <= 1'b0;
            r_lamp_bits    <= crtd_pkg::LAMP_RED;
            r_drive_pin    <= 1'b0;
            r_hold_active  <= 1'b0;
            r_hold_count   <= '0;
            r_last_level   <= '0;
            r_shown_level  <= '0;
        end else if (in_accept) begin
            r_seconds_left <= n_seconds_left;
            r_session_on   <= n_session_on;
            r_counting     <= n_counting;
            r_expired      <= n_expired;
            r_blink_phase  <= n_blink_phase;
            r_lamp_bits    <= n_lamp_bits;
            r_drive_pin    <= n_drive_pin;
            r_hold_active  <= n_hold_active;
            r_hold_count   <= n_hold_count;
            r_last_level   <= n_last_level;
            r_shown_level  <= n_shown_level;
        end
    end

    // ------------------------------------------------------------------
    // Stage one payload: status, sample flag and PWM product
    // ------------------------------------------------------------------
    crtd_pkg::t_status r_s1_status;
    logic              r_s1_sample;
    logic [PW-1:0]     r_s1_prod;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_status <= n_status;
            r_s1_sample <= (i_mode == crtd_pkg::MODE_SAMPLE);
            r_s1_prod   <= PW'(i_value) * PW'(r_pwm_top);
        end
    end

    // ------------------------------------------------------------------
    // Stage two: scale the product, load the output register
    // ------------------------------------------------------------------
    logic [15:0] duty_new;
    logic [15:0] r_duty;

    crtd_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .i_prod (r_s1_prod),
        .o_quot (duty_new)
    );

    // Hold the latest compare value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= crtd_pkg::DUTY_RST;
        end else if (out_load && r_s1_sample) begin
            r_duty <= duty_new;
        end
    end

    logic        r_motor_drive;
    logic [2:0]  r_led_colour;
    logic [6:0]  r_remaining_seconds;
    logic [6:0]  r_display_level;
    logic [15:0] r_pwm_compare;
    logic [3:0]  r_status;
    logic        r_running;
    logic        r_playing;
    logic        r_timed_out;

    // Capture the state left by the word in stage one
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_motor_drive       <= r_drive_pin;
            r_led_colour        <= r_lamp_bits;
            r_remaining_seconds <= r_seconds_left;
            r_display_level     <= r_hold_active ? r_shown_level : r_seconds_left;
            r_pwm_compare       <= r_s1_sample ? duty_new : r_duty;
            r_status            <= r_s1_status;
            r_running           <= r_session_on;
            r_playing           <= r_counting;
            r_timed_out         <= r_expired;
        end
    end

    assign o_motor_drive       = r_motor_drive;
    assign o_led_colour        = r_led_colour;
    assign o_remaining_seconds = r_remaining_seconds;
    assign o_display_level     = r_display_level;
    assign o_pwm_compare       = r_pwm_compare;
    assign o_status            = r_status;
    assign o_running           = r_running;
    assign o_playing           = r_playing;
    assign o_timed_out         = r_timed_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_in_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counting |-> r_session_on)
        else $error("counting outside a session");

    a_expired_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expired |-> (!r_session_on && (r_seconds_left == 7'd0)))
        else $error("expired timer still holds a session or seconds");

    a_hold_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_active |-> (r_hold_count != 4'd0))
        else $error("display hold active with zero count");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("word accepted while both stages are blocked");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the motor run timer with ADC display
// Drives event words through the valid/ready input channel and predicts each
// result word with a cycle-free model of the timer, lamps, hold and PWM map.
// Results are checked in order as they leave the output channel. The sender
// runs in bursts and the receiver stalls on its own pattern. Register settings
// are changed over the APB port between phases, once the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SAMPLE_BITS = crtd_pkg::SAMPLE_BITS_DEF;
    localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
    localparam int ITEM_TARGET = 1200;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF_LEN = 300;
    localparam int MAX_REPORTS = 10;

    // One expected result word
    typedef struct packed {
        logic                          motor;
        logic [crtd_pkg::LAMP_W-1:0]   led;
        logic [crtd_pkg::SEC_W-1:0]    secs;
        logic [crtd_pkg::LEVEL_W-1:0]  disp;
        logic [crtd_pkg::PWM_W-1:0]    pwm;
        crtd_pkg::t_status             status;
        logic                          running;
        logic                          playing;
        logic                          timed_out;
    } t_timer_result;

    // DUT ports
    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [3:0]             i_mode  = '0;
    logic [SAMPLE_BITS-1:0] i_value = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_motor_drive;
    logic [2:0]             o_led_colour;
    logic [6:0]             o_remaining_seconds;
    logic [6:0]             o_display_level;
    logic [15:0]            o_pwm_compare;
    logic [3:0]             o_status;
    logic                   o_running;
    logic                   o_playing;
    logic                   o_timed_out;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [3:0]             paddr   = '0;
    logic [31:0]            pwdata  = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Mirror of the register settings
    logic [crtd_pkg::HOLD_W-1:0]  cfg_hold_ticks = crtd_pkg::HOLD_TICKS_RST;
    logic [crtd_pkg::LEVEL_W-1:0] cfg_threshold  = crtd_pkg::THRESHOLD_RST;
    logic [crtd_pkg::PWM_W-1:0]   cfg_pwm_top    = crtd_pkg::PWM_TOP_RST;

    // Predicted timer state, starting from its reset values
    logic [crtd_pkg::SEC_W-1:0]   p_secs        = '0;
    logic                         p_started     = 1'b0;
    logic                         p_playing     = 1'b0;
    logic                         p_expired     = 1'b0;
    logic                         p_blink       = 1'b0;
    logic [crtd_pkg::LAMP_W-1:0]  p_lamps       = crtd_pkg::LAMP_RED;
    logic                         p_motor       = 1'b0;
    logic                         p_hold_on     = 1'b0;
    logic [crtd_pkg::HOLD_W-1:0]  p_hold_left   = '0;
    logic [crtd_pkg::LEVEL_W-1:0] p_level_ref   = '0;
    logic [crtd_pkg::LEVEL_W-1:0] p_level_shown = '0;
    logic [crtd_pkg::PWM_W-1:0]   p_duty        = crtd_pkg::DUTY_RST;

    t_timer_result pending_results[$];
    int fail_count    = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;
    int hold_off_reqs = 0;
    int hold_off_done = 0;
    int hold_off_left = 0;
    int rx_style      = 0;
    int rx_phase      = 0;
    int adc_walk      = 0;

    countdown_run_timer_with_adc_display u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_mode              (i_mode),
        .i_value             (i_value),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_motor_drive       (o_motor_drive),
        .o_led_colour        (o_led_colour),
        .o_remaining_seconds (o_remaining_seconds),
        .o_display_level     (o_display_level),
        .o_pwm_compare       (o_pwm_compare),
        .o_status            (o_status),
        .o_running           (o_running),
        .o_playing           (o_playing),
        .o_timed_out         (o_timed_out),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #5 i_clk = ~i_clk;

    // Advance the timer by one event word and return the word it should give
    function automatic t_timer_result timer_step(input logic [3:0] mode,
                                                 input logic [SAMPLE_BITS-1:0] val);
        t_timer_result     r;
        crtd_pkg::t_status st;
        int unsigned       lvl;
        int unsigned       diff;
        int unsigned       prod;
        st = crtd_pkg::ST_NONE;
        case (mode)
            crtd_pkg::MODE_TICK: begin
                // hold countdown comes first
                if (p_hold_on && p_hold_left != 0) begin
                    p_hold_left = p_hold_left - 1'b1;
                    if (p_hold_left == 0)
                        p_hold_on = 1'b0;
                end
                if (p_playing) begin
                    if (p_secs != 0) begin
                        p_motor = 1'b1;
                        p_secs  = p_secs - 1'b1;
                        p_blink = !p_blink;
                        p_lamps = p_blink ? crtd_pkg::LAMP_GREEN : crtd_pkg::LAMP_OFF;
                    end else begin
                        p_playing = 1'b0;
                        p_started = 1'b0;
                        p_expired = 1'b1;
                        p_motor   = 1'b0;
                        p_lamps   = crtd_pkg::LAMP_RED;
                        st        = crtd_pkg::ST_TIMEOUT;
                    end
                end
                if (!p_playing && p_started)
                    p_lamps = crtd_pkg::LAMP_BLUE;
            end
            crtd_pkg::MODE_BUTTON1: begin
                if (!p_started) begin
                    if (!p_expired) begin
                        p_started = 1'b1;
                        p_playing = 1'b1;
                    end
                end else begin
                    p_started = 1'b0;
                    p_playing = 1'b0;
                    p_secs    = '0;
                end
            end
            crtd_pkg::MODE_BUTTON2: begin
                if (p_started)
                    p_playing = !p_playing;
            end
            crtd_pkg::MODE_SET: begin
                if (val < crtd_pkg::SET_LIMIT) begin
                    p_secs    = val[crtd_pkg::SEC_W-1:0];
                    p_expired = 1'b0;
                    p_lamps   = crtd_pkg::LAMP_GREEN;
                    p_blink   = 1'b1;
                    st        = crtd_pkg::ST_OK;
                end else begin
                    st = crtd_pkg::ST_RANGE;
                end
            end
            crtd_pkg::MODE_START: begin
                if (p_started) begin
                    st = crtd_pkg::ST_RUNNING;
                end else if (p_secs == 0) begin
                    st = crtd_pkg::ST_NOT_SET;
                end else begin
                    p_started = 1'b1;
                    p_playing = 1'b1;
                    st        = crtd_pkg::ST_OK;
                end
            end
            crtd_pkg::MODE_STOP: begin
                if (p_started) begin
                    p_started = 1'b0;
                    p_playing = 1'b0;
                    p_secs    = '0;
                    st        = crtd_pkg::ST_OK;
                end else begin
                    st = crtd_pkg::ST_STOPPED;
                end
            end
            crtd_pkg::MODE_PAUSE: begin
                if (!p_started) begin
                    st = crtd_pkg::ST_NOT_RUNNING;
                end else if (p_playing) begin
                    p_playing = 1'b0;
                    st        = crtd_pkg::ST_OK;
                end else begin
                    st = crtd_pkg::ST_PAUSED;
                end
            end
            crtd_pkg::MODE_RESUME: begin
                if (!p_started) begin
                    st = crtd_pkg::ST_NOT_RUNNING;
                end else if (!p_playing) begin
                    p_playing = 1'b1;
                    st        = crtd_pkg::ST_OK;
                end else begin
                    st = crtd_pkg::ST_RESUMED;
                end
            end
            crtd_pkg::MODE_SAMPLE: begin
                // exact integer floors of the level and the compare value
                lvl    = (32'(val) * crtd_pkg::LEVEL_SCALE) / FULL_SCALE;
                prod   = 32'(val) * 32'(cfg_pwm_top);
                p_duty = 16'(prod / FULL_SCALE);
                diff   = (lvl > p_level_ref) ? lvl - p_level_ref : p_level_ref - lvl;
                if (diff > cfg_threshold) begin
                    p_level_ref   = lvl[crtd_pkg::LEVEL_W-1:0];
                    p_level_shown = lvl[crtd_pkg::LEVEL_W-1:0];
                    p_hold_left   = cfg_hold_ticks;
                    p_hold_on     = (cfg_hold_ticks != 0);
                end
            end
            default: begin
            end
        endcase
        r.motor     = p_motor;
        r.led       = p_lamps;
        r.secs      = p_secs;
        r.disp      = p_hold_on ? p_level_shown : p_secs;
        r.pwm       = p_duty;
        r.status    = st;
        r.running   = p_started;
        r.playing   = p_playing;
        r.timed_out = p_expired;
        return r;
    endfunction

    // Offer one word and hold it until accepted; valid stays high afterwards
    task automatic send_word(input logic [3:0] mode, input logic [SAMPLE_BITS-1:0] val);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= val;
        do
            @(posedge i_clk);
        while (!o_ready);
        pending_results.push_back(timer_step(mode, val));
        if (mode <= crtd_pkg::MODE_SAMPLE)
            items_sent++;
    endtask

    // Drop valid and idle for a number of cycles
    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Send in bursts of random length with random gaps between them
    task automatic send_paced(input logic [3:0] mode, input logic [SAMPLE_BITS-1:0] val);
        if (burst_left == 0) begin
            idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_word(mode, val);
    endtask

    // Hold the sender until every expected word is back, then let the pipe settle
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input crtd_pkg::t_reg idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        case (idx)
            crtd_pkg::REG_HOLD_TICKS: cfg_hold_ticks = data[crtd_pkg::HOLD_W-1:0];
            crtd_pkg::REG_THRESHOLD:  cfg_threshold  = data[crtd_pkg::LEVEL_W-1:0];
            crtd_pkg::REG_PWM_TOP:    cfg_pwm_top    = data[crtd_pkg::PWM_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input int hold, input int thresh, input int top);
        wait_drain();
        write_reg(crtd_pkg::REG_HOLD_TICKS, hold);
        write_reg(crtd_pkg::REG_THRESHOLD, thresh);
        write_reg(crtd_pkg::REG_PWM_TOP, top);
    endtask

    // Next ADC sample: mostly a random walk, sometimes a jump
    function automatic logic [SAMPLE_BITS-1:0] next_sample();
        if ($urandom_range(0, 3) == 0)
            adc_walk = $urandom_range(0, FULL_SCALE);
        else
            adc_walk = adc_walk + $urandom_range(0, 300) - 150;
        if (adc_walk < 0)
            adc_walk = 0;
        if (adc_walk > FULL_SCALE)
            adc_walk = FULL_SCALE;
        return adc_walk[SAMPLE_BITS-1:0];
    endfunction

    // One well-formed session: set, start, then mostly ticks with commands mixed in
    task automatic run_session(input bit paced);
        int n;
        int pick;
        logic [3:0]             mode;
        logic [SAMPLE_BITS-1:0] val;
        n = $urandom_range(5, 40);
        for (int k = 0; k < n + 2; k++) begin
            val = '0;
            if (k == 0) begin
                mode = crtd_pkg::MODE_SET;
                val  = ($urandom_range(0, 7) == 0)
                           ? $urandom_range(0, crtd_pkg::SET_LIMIT - 1)
                           : $urandom_range(0, 10);
            end else if (k == 1) begin
                mode = $urandom_range(0, 1) ? crtd_pkg::MODE_START : crtd_pkg::MODE_BUTTON1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 58) begin
                    mode = crtd_pkg::MODE_TICK;
                end else if (pick < 68) begin
                    mode = crtd_pkg::MODE_SAMPLE;
                    val  = next_sample();
                end else if (pick < 74) begin
                    mode = crtd_pkg::MODE_PAUSE;
                end else if (pick < 80) begin
                    mode = crtd_pkg::MODE_RESUME;
                end else if (pick < 84) begin
                    mode = crtd_pkg::MODE_BUTTON2;
                end else if (pick < 87) begin
                    mode = crtd_pkg::MODE_START;
                end else if (pick < 90) begin
                    mode = crtd_pkg::MODE_SET;
                    val  = $urandom_range(0, FULL_SCALE);
                end else if (pick < 92) begin
                    mode = crtd_pkg::MODE_STOP;
                end else if (pick < 94) begin
                    mode = crtd_pkg::MODE_BUTTON1;
                end else begin
                    // noise: any code, any value
                    mode = $urandom_range(0, 15);
                    val  = $urandom_range(0, FULL_SCALE);
                end
            end
            if (paced)
                send_paced(mode, val);
            else
                send_word(mode, val);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Each command status, timeout paths, set range, samples and unused codes
    task automatic test_directed();
        send_word(crtd_pkg::MODE_START, 0);
        send_word(crtd_pkg::MODE_STOP, 0);
        send_word(crtd_pkg::MODE_PAUSE, 0);
        send_word(crtd_pkg::MODE_RESUME, 0);
        send_word(crtd_pkg::MODE_SET, crtd_pkg::SET_LIMIT);
        send_word(crtd_pkg::MODE_SET, FULL_SCALE);
        send_word(crtd_pkg::MODE_BUTTON1, 0);
        send_word(crtd_pkg::MODE_TICK, 0);
        send_word(crtd_pkg::MODE_BUTTON1, 0);
        send_word(crtd_pkg::MODE_SET, crtd_pkg::SET_LIMIT - 1);
        send_word(crtd_pkg::MODE_START, 0);
        send_word(crtd_pkg::MODE_START, 0);
        send_word(crtd_pkg::MODE_TICK, 0);
        send_word(crtd_pkg::MODE_PAUSE, 0);
        send_word(crtd_pkg::MODE_PAUSE, 0);
        send_word(crtd_pkg::MODE_TICK, 0);
        send_word(crtd_pkg::MODE_RESUME, 0);
        send_word(crtd_pkg::MODE_RESUME, 0);
        send_word(crtd_pkg::MODE_SET, 0);
        send_word(crtd_pkg::MODE_SAMPLE, FULL_SCALE);
        send_word(crtd_pkg::MODE_SAMPLE, FULL_SCALE - 1);
        send_word(crtd_pkg::MODE_TICK, 0);
        send_word(crtd_pkg::MODE_SAMPLE, 0);
        send_word(4'd9, FULL_SCALE);
        send_word(4'd15, 0);
        send_word(crtd_pkg::MODE_BUTTON2, 0);
        send_word(crtd_pkg::MODE_BUTTON1, 0);
    endtask

    // Traffic under several register settings, extremes included
    task automatic test_config_sweep();
        int hold_set[6]   = '{5, 0, 15, 1, 15, 0};
        int thresh_set[6] = '{2, 0, 99, 0, 1, 0};
        int top_set[6]    = '{4999, 1, 65535, 65535, 1, 0};
        int goal;
        for (int s = 0; s < 6; s++) begin
            if (s == 5)
                apply_config($urandom_range(0, 15), $urandom_range(0, 99),
                             $urandom_range(1, 65535));
            else
                apply_config(hold_set[s], thresh_set[s], top_set[s]);
            goal = items_sent + 110;
            while (items_sent < goal)
                run_session(1'b1);
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        hold_off_reqs++;
        run_session(1'b0);
        run_session(1'b0);
        wait_drain();
    endtask

    // Sender pauses until every expected word has come back
    task automatic test_drain_pause();
        run_session(1'b1);
        wait_drain();
        run_session(1'b0);
    endtask

    // Mixed sessions to the item target, with a fresh setting now and then
    task automatic test_random_traffic();
        int next_cfg;
        next_cfg = items_sent + 200;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= next_cfg) begin
                apply_config($urandom_range(0, 15), $urandom_range(0, 99),
                             $urandom_range(1, 65535));
                next_cfg = items_sent + 200;
            end
            run_session(1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus the long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_phase++;
        if (hold_off_reqs > hold_off_done && hold_off_left == 0) begin
            hold_off_done++;
            hold_off_left = HOLD_OFF_LEN;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_ready <= 1'b0;
        end else begin
            if (rx_phase % 97 == 0)
                rx_style = $urandom_range(0, 3);
            case (rx_style)
                0:       i_ready <= 1'b1;
                1:       i_ready <= $urandom_range(0, 1);
                2:       i_ready <= (rx_phase % 5) != 0;
                default: i_ready <= $urandom_range(0, 9) != 0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Check each result word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_motor_drive, o_led_colour, o_remaining_seconds, o_display_level,
                    o_pwm_compare, crtd_pkg::t_status'(o_status), o_running, o_playing,
                    o_timed_out};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result word at %0t", $realtime);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch at %0t: motor %0d/%0d led %0d/%0d secs %0d/%0d",
                                 $realtime, want.motor, got.motor, want.led, got.led,
                                 want.secs, got.secs);
                        $display("  disp %0d/%0d pwm %0d/%0d status %0d/%0d run %0d/%0d",
                                 want.disp, got.disp, want.pwm, got.pwm, want.status,
                                 got.status, want.running, got.running);
                        $display("  play %0d/%0d timed_out %0d/%0d (expected/actual)",
                                 want.playing, got.playing, want.timed_out, got.timed_out);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/crtd_pkg.sv
hw/rtl/crtd_div.sv
hw/rtl/countdown_run_timer_with_adc_display.sv
dv/tb_top.sv
